[hw/rtl/perceptron_trainer_macros.svh]
// Assertion macros for the perceptron trainer RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef PERCEPTRON_TRAINER_MACROS_SVH
`define PERCEPTRON_TRAINER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pt_pkg.sv]
// Shared types, constants and helpers of the perceptron trainer.
// No dependencies; the RTL modules and interfaces import it.
package pt_pkg;

   localparam int COORD_W    = 32;
   localparam int W_W        = 48;
   localparam int ACC_W      = 88;
   localparam int IDX_W      = 5;
   localparam int MISS_W     = 11;
   localparam int DIM_W      = 5;
   localparam int RATE_W     = 20;
   localparam int PLIM_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [DIM_W-1:0]  DIM_RESET  = 5'd2;
   localparam logic [RATE_W-1:0] RATE_RESET = 20'd65536;
   localparam logic [PLIM_W-1:0] PLIM_RESET = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIMENSION     = 2'd0,
      CSR_LEARNING_RATE = 2'd1,
      CSR_PASS_LIMIT    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_HOLD,
      MUL_LO,
      MUL_HI,
      MUL_RATE
   } mul_sel_type;

   typedef struct packed {
      logic        clear;
      mul_sel_type sel;
      logic        acc_en;
      logic        neg;
   } mac_ctl_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_EV_START,
      ST_EV_RD,
      ST_EV_LO,
      ST_EV_HI,
      ST_EV_FIN,
      ST_DECIDE,
      ST_UP_RD,
      ST_UP_MUL,
      ST_UP_ADD,
      ST_ADVANCE,
      ST_COUNT_START,
      ST_EMIT
   } state_type;

   // Clamp a sum that grew by one bit back into the weight range.
   function automatic logic signed [W_W-1:0] sat_weight(input logic signed [W_W:0] v);
      logic signed [W_W-1:0] r;
      if (v[W_W] != v[W_W-1]) begin
         r = v[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
      end else begin
         r = v[W_W-1:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/pt_ifs.sv]
// Channel interfaces of the perceptron trainer: request, response and CSR write.
// Depends on pt_pkg for field widths.
interface pt_req_if import pt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] coord;
   logic                      label;
   logic                      last_coord;
   logic                      last_point;
   modport source(output valid, coord, label, last_coord, last_point, input ready);
   modport sink(input valid, coord, label, last_coord, last_point, output ready);
endinterface

interface pt_rsp_if import pt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [IDX_W-1:0]      weight_index;
   logic signed [W_W-1:0] weight_value;
   logic [MISS_W-1:0]     miss_count;
   logic                  converged;
   logic                  final_word;
   modport source(output valid, weight_index, weight_value, miss_count, converged,
                  final_word, input ready);
   modport sink(input valid, weight_index, weight_value, miss_count, converged,
                final_word, output ready);
endinterface

interface pt_csr_if import pt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/pt_store.sv]
// Point and label memories: one write port and one registered read port each.
// Depends on pt_pkg for the coordinate width.
module pt_store import pt_pkg::*; #(
   parameter int POINTS = 1024,
   parameter int DIMS   = 16,
   parameter int AW     = 14,
   parameter int LAW    = 10
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic signed [COORD_W-1:0] wr_data,
   input  logic                      lbl_wr_en,
   input  logic [LAW-1:0]            lbl_wr_addr,
   input  logic                      lbl_wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic signed [COORD_W-1:0] rd_data,
   input  logic [LAW-1:0]            lbl_rd_addr,
   output logic                      lbl_rd_data
);

   logic signed [COORD_W-1:0] point_mem [POINTS*DIMS];
   logic                      label_mem [POINTS];
   logic signed [COORD_W-1:0] rd_data_ff;
   logic                      lbl_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= point_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lbl_wr_en) begin
         label_mem[lbl_wr_addr] <= lbl_wr_data;
      end
      lbl_rd_ff <= label_mem[lbl_rd_addr];
   end

   assign rd_data     = rd_data_ff;
   assign lbl_rd_data = lbl_rd_ff;

endmodule

[hw/rtl/pt_mac.sv]
// Shared multiplier and wide accumulator of the perceptron trainer.
// Depends on pt_pkg for widths and the control struct.
module pt_mac import pt_pkg::*; (
   input  logic                      clock,
   input  mac_ctl_type               ctl,
   input  logic signed [W_W-1:0]     weight,
   input  logic signed [COORD_W:0]   x,
   input  logic [RATE_W-1:0]         rate,
   output logic                      acc_neg,
   output logic [2*COORD_W-1:0]      prod
);

   logic [W_W-1:0]           mw;
   logic [COORD_W:0]         mx_full;
   logic [COORD_W-1:0]       mx;
   logic [COORD_W-1:0]       opa;
   logic [2*COORD_W-1:0]     prod_ff, prod_in;
   logic                     hi_ff, hi_in;
   logic                     neg_ff, neg_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]         term;

   always_comb begin
      mw      = weight[W_W-1] ? W_W'(-weight) : W_W'(weight);
      mx_full = x[COORD_W] ? (COORD_W+1)'(-x) : (COORD_W+1)'(x);
      mx      = mx_full[COORD_W-1:0];
      unique case (ctl.sel)
         MUL_LO:   opa = mw[COORD_W-1:0];
         MUL_HI:   opa = COORD_W'(mw[W_W-1:COORD_W]);
         MUL_RATE: opa = COORD_W'(rate);
         default:  opa = '0;
      endcase
   end

   always_comb begin
      prod_in = prod_ff;
      hi_in   = hi_ff;
      neg_in  = neg_ff;
      if (ctl.sel != MUL_HOLD) begin
         prod_in = (2*COORD_W)'(opa) * (2*COORD_W)'(mx);
         hi_in   = (ctl.sel == MUL_HI);
         neg_in  = ctl.neg;
      end
      // The upper partial product carries the weight bits above the low word.
      term = hi_ff ? (ACC_W'(prod_ff) << COORD_W) : ACC_W'(prod_ff);
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = neg_ff ? (acc_ff - $signed(term)) : (acc_ff + $signed(term));
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      hi_ff   <= hi_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
   end

   assign acc_neg = acc_ff[ACC_W-1];
   assign prod    = prod_ff;

endmodule

[hw/rtl/perceptron_trainer.sv]
// Top level of the perceptron trainer: CSRs, sequencer and weight registers.
// Depends on pt_pkg, pt_ifs, pt_store, pt_mac and perceptron_trainer_macros.svh.
//
//   Channel   Role     Beat carries
//   req_ch    sink     one coordinate with label, last_coord, last_point
//   rsp_ch    source   one weight with index, miss count, converged, final_word
//   csr_ch    sink     register index and write data, always ready
//
// Loading takes one coordinate beat per cycle while req_ch.valid is high. The beat with last_point starts
// training and req_ch stays low until the final response beat is taken.
// Each evaluation of a point runs EV_START, then EV_RD, EV_LO, EV_HI and EV_FIN
// per weight through the shared multiplier; an update runs UP_RD, UP_MUL and
// UP_ADD per weight, ADVANCE steps to the next point; dim+1 response beats end the run.
// Reset is synchronous; the memories are not cleared by it.
`include "perceptron_trainer_macros.svh"

module perceptron_trainer import pt_pkg::*; #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIM    = 16,
   parameter int FRAC_BITS  = 16
) (
   input logic clock,
   input logic reset,
   pt_req_if.sink   req_ch,
   pt_rsp_if.source rsp_ch,
   pt_csr_if.sink   csr_ch
);

   localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int RW  = PCW + 1;
   localparam int KW  = $clog2(MAX_DIM + 1);
   localparam int AW  = $clog2(MAX_POINTS * MAX_DIM);
   localparam int LW  = PLIM_W + 1;
   localparam logic [COORD_W:0] BIAS_X = (COORD_W+1)'(1) << FRAC_BITS;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]  dim_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [PLIM_W-1:0] plim_ff;

   logic [PCW-1:0]    pc_ff, pc_in;
   logic [KW-1:0]     ci_ff, ci_in;
   logic [PW-1:0]     pt_ff, pt_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [PCW-1:0]    run_ff, run_in;
   logic [PCW-1:0]    miss_ff, miss_in;
   logic [PLIM_W-1:0] pass_ff, pass_in;
   logic              conv_ff, conv_in;
   logic              cnt_ff, cnt_in;

   logic signed [W_W-1:0] weights_ff [MAX_DIM+1];
   logic                  w_clear, w_wr;
   logic signed [W_W-1:0] w_new;

   logic [KW-1:0]             dim_eff;
   logic                      req_acc, rsp_acc;
   logic                      last_k, last_pt, run_full, pass_done, is_miss;
   logic                      st_wr_en, lbl_wr_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic signed [COORD_W-1:0] rd_data;
   logic                      lbl_rd;
   logic signed [COORD_W:0]   x_op;
   logic signed [W_W-1:0]     w_cur;
   logic                      up_neg;
   logic [W_W:0]              delta;
   logic signed [W_W:0]       w_sum;
   mac_ctl_type               mac_ctl;
   logic                      mac_acc_neg;
   logic [2*COORD_W-1:0]      mac_prod;

   // ---------------- CSR ----------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff  <= DIM_RESET;
         rate_ff <= RATE_RESET;
         plim_ff <= PLIM_RESET;
      end else if (csr_ch.valid) begin
         priority case (csr_ch.index)
            CSR_DIMENSION:     dim_ff  <= csr_ch.data[DIM_W-1:0];
            CSR_LEARNING_RATE: rate_ff <= csr_ch.data[RATE_W-1:0];
            CSR_PASS_LIMIT:    plim_ff <= csr_ch.data[PLIM_W-1:0];
            default:           ;
         endcase
      end
   end

   // ---------------- flags ----------------
   always_comb begin
      if (32'(dim_ff) > MAX_DIM) begin
         dim_eff = KW'(MAX_DIM);
      end else begin
         dim_eff = KW'(dim_ff);
      end
   end

   assign req_acc   = req_ch.valid && req_ch.ready;
   assign rsp_acc   = rsp_ch.valid && rsp_ch.ready;
   assign last_k    = (k_ff == dim_eff);
   assign last_pt   = ((PCW'(pt_ff) + PCW'(1)) == pc_ff);
   assign run_full  = ((RW'(run_ff) + RW'(1)) >= RW'(pc_ff));
   assign pass_done = ((LW'(pass_ff) + LW'(1)) >= LW'(plim_ff));
   // Class +1 when the sum is not negative; label 1 stands for class -1.
   assign is_miss   = (!mac_acc_neg) == lbl_rd;

   // ---------------- memories ----------------
   assign st_wr_en  = req_acc && (32'(pc_ff) < MAX_POINTS) && (32'(ci_ff) < MAX_DIM);
   assign lbl_wr_en = req_acc && (req_ch.last_coord || req_ch.last_point)
                      && (32'(pc_ff) < MAX_POINTS);
   assign wr_addr   = AW'(PW'(pc_ff)) * AW'(MAX_DIM) + AW'(ci_ff);
   assign rd_addr   = AW'(pt_ff) * AW'(MAX_DIM) + AW'(KW'(k_ff - KW'(1)));

   pt_store #(
      .POINTS (MAX_POINTS),
      .DIMS   (MAX_DIM),
      .AW     (AW),
      .LAW    (PW)
   ) u_store (
      .clock       (clock),
      .wr_en       (st_wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (req_ch.coord),
      .lbl_wr_en   (lbl_wr_en),
      .lbl_wr_addr (PW'(pc_ff)),
      .lbl_wr_data (req_ch.label),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .lbl_rd_addr (pt_ff),
      .lbl_rd_data (lbl_rd)
   );

   // ---------------- shared arithmetic ----------------
   assign w_cur = weights_ff[k_ff];
   assign x_op  = (k_ff == '0) ? $signed(BIAS_X) : (COORD_W+1)'(rd_data);

   pt_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .weight  (w_cur),
      .x       (x_op),
      .rate    (rate_ff),
      .acc_neg (mac_acc_neg),
      .prod    (mac_prod)
   );

   assign up_neg = lbl_rd ^ ((k_ff != '0) && rd_data[COORD_W-1]);
   assign delta  = (k_ff == '0) ? (W_W+1)'(rate_ff) : (W_W+1)'(mac_prod >> FRAC_BITS);
   assign w_sum  = up_neg ? ((W_W+1)'(w_cur) - $signed(delta))
                          : ((W_W+1)'(w_cur) + $signed(delta));
   assign w_new  = sat_weight(w_sum);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:        if (req_acc && req_ch.last_point) state_in = ST_INIT;
         ST_INIT: begin
            if (pc_ff == '0 || plim_ff == '0) state_in = ST_COUNT_START;
            else                              state_in = ST_EV_START;
         end
         ST_EV_START:    state_in = ST_EV_RD;
         ST_EV_RD:       state_in = ST_EV_LO;
         ST_EV_LO:       state_in = ST_EV_HI;
         ST_EV_HI:       state_in = ST_EV_FIN;
         ST_EV_FIN:      state_in = last_k ? ST_DECIDE : ST_EV_RD;
         ST_DECIDE: begin
            if (cnt_ff)        state_in = last_pt ? ST_EMIT : ST_EV_START;
            else if (is_miss)  state_in = ST_UP_RD;
            else if (run_full) state_in = ST_COUNT_START;
            else               state_in = ST_ADVANCE;
         end
         ST_UP_RD:       state_in = ST_UP_MUL;
         ST_UP_MUL:      state_in = ST_UP_ADD;
         ST_UP_ADD:      state_in = last_k ? ST_ADVANCE : ST_UP_RD;
         ST_ADVANCE: begin
            if (last_pt && pass_done) state_in = ST_COUNT_START;
            else                      state_in = ST_EV_START;
         end
         ST_COUNT_START: state_in = (pc_ff == '0) ? ST_EMIT : ST_EV_START;
         ST_EMIT:        if (rsp_acc && last_k) state_in = ST_LOAD;
         default:        state_in = ST_LOAD;
      endcase
   end

   // ---------------- outputs and counters ----------------
   always_comb begin
      pc_in   = pc_ff;
      ci_in   = ci_ff;
      pt_in   = pt_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      miss_in = miss_ff;
      pass_in = pass_ff;
      conv_in = conv_ff;
      cnt_in  = cnt_ff;
      w_clear = 1'b0;
      w_wr    = 1'b0;
      mac_ctl = '{clear: 1'b0, sel: MUL_HOLD, acc_en: 1'b0, neg: 1'b0};
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ch.ready = 1'b1;
            if (req_acc) begin
               if (32'(ci_ff) < MAX_DIM) ci_in = ci_ff + KW'(1);
               if (req_ch.last_coord || req_ch.last_point) begin
                  if (32'(pc_ff) < MAX_POINTS) pc_in = pc_ff + PCW'(1);
                  ci_in = '0;
               end
            end
         end
         ST_INIT: begin
            w_clear = 1'b1;
            pass_in = '0;
            run_in  = '0;
            conv_in = 1'b0;
            cnt_in  = 1'b0;
            pt_in   = '0;
         end
         ST_EV_START: begin
            mac_ctl.clear = 1'b1;
            k_in = '0;
         end
         ST_EV_RD: ;
         ST_EV_LO: begin
            mac_ctl.sel = MUL_LO;
            mac_ctl.neg = w_cur[W_W-1] ^ x_op[COORD_W];
         end
         ST_EV_HI: begin
            mac_ctl.sel    = MUL_HI;
            mac_ctl.neg    = w_cur[W_W-1] ^ x_op[COORD_W];
            mac_ctl.acc_en = 1'b1;
         end
         ST_EV_FIN: begin
            mac_ctl.acc_en = 1'b1;
            if (!last_k) k_in = k_ff + KW'(1);
         end
         ST_DECIDE: begin
            k_in = '0;
            if (cnt_ff) begin
               miss_in = miss_ff + PCW'(is_miss);
               if (!last_pt) pt_in = pt_ff + PW'(1);
            end else if (is_miss) begin
               run_in = '0;
            end else begin
               run_in = run_ff + PCW'(1);
               if (run_full) conv_in = 1'b1;
            end
         end
         ST_UP_RD: ;
         ST_UP_MUL: begin
            mac_ctl.sel = MUL_RATE;
         end
         ST_UP_ADD: begin
            w_wr = 1'b1;
            if (!last_k) k_in = k_ff + KW'(1);
         end
         ST_ADVANCE: begin
            if (last_pt) begin
               pt_in   = '0;
               pass_in = pass_ff + PLIM_W'(1);
            end else begin
               pt_in = pt_ff + PW'(1);
            end
         end
         ST_COUNT_START: begin
            cnt_in  = 1'b1;
            pt_in   = '0;
            miss_in = '0;
            k_in    = '0;
         end
         ST_EMIT: begin
            rsp_ch.valid = 1'b1;
            if (rsp_acc) begin
               if (last_k) begin
                  pc_in = '0;
                  ci_in = '0;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.weight_index = IDX_W'(k_ff);
   assign rsp_ch.weight_value = w_cur;
   assign rsp_ch.miss_count   = MISS_W'(miss_ff);
   assign rsp_ch.converged    = conv_ff;
   assign rsp_ch.final_word   = last_k;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         pc_ff    <= '0;
         ci_ff    <= '0;
         pt_ff    <= '0;
         k_ff     <= '0;
         run_ff   <= '0;
         miss_ff  <= '0;
         pass_ff  <= '0;
         conv_ff  <= 1'b0;
         cnt_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         ci_ff    <= ci_in;
         pt_ff    <= pt_in;
         k_ff     <= k_in;
         run_ff   <= run_in;
         miss_ff  <= miss_in;
         pass_ff  <= pass_in;
         conv_ff  <= conv_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || w_clear) begin
         for (int i = 0; i <= MAX_DIM; i++) begin
            weights_ff[i] <= '0;
         end
      end else if (w_wr) begin
         weights_ff[k_ff] <= w_new;
      end
   end

   // ---------------- assertions ----------------
   `PT_ASSERT_IMP(a_rsp_blocks_req, clock, reset, rsp_ch.valid, !req_ch.ready,
                  "request side open while responses are pending")
   `PT_ASSERT_IMP(a_final_index, clock, reset, rsp_ch.valid && rsp_ch.final_word,
                  rsp_ch.weight_index == IDX_W'(dim_eff), "final beat on wrong weight index")
   `PT_ASSERT_NXT(a_train_start, clock, reset, req_acc && req_ch.last_point,
                  !req_ch.ready && !rsp_ch.valid, "training did not start after last point")
   `PT_ASSERT_NXT(a_run_end, clock, reset, rsp_acc && rsp_ch.final_word,
                  req_ch.ready && pc_ff == '0, "load state not restored after final beat")

endmodule

[tb/pt_checker.sv]
// Scoreboard for the perceptron trainer: watches the CSR, request and response channels.
// Predicts every response beat from its own copy of the store and weights.
// Depends on pt_pkg and the channel interfaces in pt_ifs.
module pt_checker import pt_pkg::*; #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIM    = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   pt_req_if    req,
   pt_rsp_if    rsp,
   pt_csr_if    csr,
   output int   failures,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [IDX_W-1:0]      index;
      logic signed [W_W-1:0] value;
      logic [MISS_W-1:0]     misses;
      logic                  conv;
      logic                  last;
   } weight_beat_type;

   localparam logic signed [W_W:0] W_HI = (49'sd1 <<< (W_W-1)) - 49'sd1;
   localparam logic signed [W_W:0] W_LO = -(49'sd1 <<< (W_W-1));

   logic signed [COORD_W-1:0] points [0:MAX_POINTS*MAX_DIM-1];
   logic                      labels [0:MAX_POINTS-1];
   logic signed [W_W-1:0]     weights [0:MAX_DIM];
   int unsigned               n_points, coord_pos;
   logic [DIM_W-1:0]          dim_reg;
   logic [RATE_W-1:0]         rate_reg;
   logic [PLIM_W-1:0]         plim_reg;
   weight_beat_type           expected_weights [$];

   function automatic logic signed [W_W-1:0] clamp(input logic signed [W_W:0] s);
      if (s > W_HI) return W_HI[W_W-1:0];
      if (s < W_LO) return W_LO[W_W-1:0];
      return s[W_W-1:0];
   endfunction

   function automatic bit misclassified(input int unsigned p, input int unsigned d);
      logic signed [95:0] acc, w, x;
      w = weights[0];
      acc = w <<< FRAC_BITS;
      for (int k = 0; k < d; k++) begin
         w = weights[k+1];
         x = points[p*MAX_DIM+k];
         acc = acc + w * x;
      end
      return (!acc[95]) != (labels[p] == 1'b0);
   endfunction

   function automatic void nudge(input int unsigned p, input int unsigned d);
      logic signed [W_W:0] delta, sum;
      logic signed [COORD_W-1:0] x;
      logic [COORD_W-1:0] mx;
      logic [51:0] prod;
      delta = $signed({29'b0, rate_reg});
      if (labels[p]) delta = -delta;
      sum = weights[0] + delta;
      weights[0] = clamp(sum);
      for (int k = 0; k < d; k++) begin
         x = points[p*MAX_DIM+k];
         mx = x[COORD_W-1] ? ~x + 1'b1 : x;
         prod = 52'(rate_reg) * 52'(mx);
         delta = $signed({13'b0, prod[51:FRAC_BITS]});
         if (labels[p] != x[COORD_W-1]) delta = -delta;
         sum = weights[k+1] + delta;
         weights[k+1] = clamp(sum);
      end
   endfunction

   // Runs the whole training and queues the dim+1 weight beats it ends with.
   function automatic void train_and_queue();
      int unsigned d, run, misses;
      bit conv;
      weight_beat_type b;
      d = (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
      run = 0;
      misses = 0;
      conv = 0;
      for (int k = 0; k <= MAX_DIM; k++) weights[k] = '0;
      for (int pass = 0; pass < plim_reg && !conv && n_points > 0; pass++) begin
         for (int i = 0; i < n_points; i++) begin
            if (misclassified(i, d)) begin
               run = 0;
               nudge(i, d);
            end else begin
               run++;
            end
            if (run >= n_points) begin
               conv = 1;
               break;
            end
         end
      end
      for (int i = 0; i < n_points; i++)
         if (misclassified(i, d)) misses++;
      for (int k = 0; k <= d; k++) begin
         b.index = IDX_W'(k);
         b.value = weights[k];
         b.misses = MISS_W'(misses);
         b.conv = conv;
         b.last = (k == d);
         expected_weights.push_back(b);
      end
      n_points = 0;
      coord_pos = 0;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("%0t checker: %s expected %0d got %0d", $realtime, what, want, got);
      failures++;
   endtask

   initial begin
      failures = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      weight_beat_type b;
      if (reset) begin
         for (int k = 0; k <= MAX_DIM; k++) weights[k] = '0;
         n_points = 0;
         coord_pos = 0;
         dim_reg = DIM_RESET;
         rate_reg = RATE_RESET;
         plim_reg = PLIM_RESET;
         expected_weights.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr_index_type'(csr.index))
               CSR_DIMENSION:     dim_reg = csr.data[DIM_W-1:0];
               CSR_LEARNING_RATE: rate_reg = csr.data;
               CSR_PASS_LIMIT:    plim_reg = csr.data[PLIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_weights.size() == 0) begin
               report_mismatch("unexpected beat, index", -1, rsp.weight_index);
            end else begin
               b = expected_weights.pop_front();
               if (rsp.weight_index !== b.index)
                  report_mismatch("weight_index", b.index, rsp.weight_index);
               if (rsp.weight_value !== b.value)
                  report_mismatch("weight_value", b.value, rsp.weight_value);
               if (rsp.miss_count !== b.misses)
                  report_mismatch("miss_count", b.misses, rsp.miss_count);
               if (rsp.converged !== b.conv)
                  report_mismatch("converged", b.conv, rsp.converged);
               if (rsp.final_word !== b.last)
                  report_mismatch("final_word", b.last, rsp.final_word);
            end
         end
         if (req.valid && req.ready) begin
            if (n_points < MAX_POINTS && coord_pos < MAX_DIM)
               points[n_points*MAX_DIM+coord_pos] = req.coord;
            if (coord_pos < MAX_DIM) coord_pos++;
            if (req.last_coord || req.last_point) begin
               if (n_points < MAX_POINTS) begin
                  labels[n_points] = req.label;
                  n_points++;
               end
               coord_pos = 0;
            end
            if (req.last_point) train_and_queue();
         end
      end
      outstanding = expected_weights.size();
   end

endmodule

[tb/tb.sv]
// Testbench top for the perceptron trainer: clock, reset, stimulus and verdict.
// Depends on pt_pkg, pt_ifs, perceptron_trainer and pt_checker.
module tb;
   import pt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POINTS = 1024;
   localparam int MAX_DIM    = 16;

   logic clock = 0;
   logic reset;
   int   failures, outstanding;
   int   sender_pct, receiver_pct;
   int   beats_sent;
   int   load_point;
   int   dim_now;
   bit   slot_written [0:MAX_POINTS-1][0:MAX_DIM-1];

   pt_req_if req_ch ();
   pt_rsp_if rsp_ch ();
   pt_csr_if csr_ch ();

   perceptron_trainer uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   pt_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .failures   (failures),
      .outstanding(outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_pct);
   end

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      endcase
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      forever begin
         @(negedge clock);
         if (csr_ch.ready) break;
      end
      @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_DIMENSION) dim_now = value[DIM_W-1:0];
   endtask

   task automatic send_beat(input logic signed [COORD_W-1:0] c, input logic lab,
                            input logic lc, input logic lp);
      while ($urandom_range(99) < sender_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.coord      <= c;
      req_ch.label      <= lab;
      req_ch.last_coord <= lc;
      req_ch.last_point <= lp;
      forever begin
         @(negedge clock);
         if (req_ch.ready) break;
      end
      @(posedge clock);
      beats_sent++;
   endtask

   // A point closed early must find the missing slots written by an earlier load.
   function automatic bit short_ok(input int n, input int d);
      if (load_point >= MAX_POINTS) return 1'b0;
      for (int k = n; k < d; k++)
         if (!slot_written[load_point][k]) return 1'b0;
      return 1'b1;
   endfunction

   // Sends one point of n coordinates. With by_rule set, the class follows the
   // sign of the first coordinate so that the set tends to be separable.
   task automatic send_point(input int n, input bit by_rule, input bit closes_run,
                             input bit with_last_coord);
      logic signed [COORD_W-1:0] c [$];
      logic lab;
      for (int j = 0; j < n; j++) c.push_back(pick_coord());
      lab = by_rule ? c[0][COORD_W-1] : 1'($urandom_range(1));
      for (int j = 0; j < n; j++) begin
         if (load_point < MAX_POINTS && j < MAX_DIM) slot_written[load_point][j] = 1'b1;
         send_beat(c[j], lab, (j == n - 1) && (!closes_run || with_last_coord),
                   (j == n - 1) && closes_run);
      end
      if (closes_run) begin
         req_ch.valid <= 1'b0;
         load_point = 0;
      end else if (load_point < MAX_POINTS) begin
         load_point++;
      end
   endtask

   task automatic settle();
      do @(negedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_run();
      int d, n_pts, n, base;
      bit by_rule;
      d = (dim_now > MAX_DIM) ? MAX_DIM : dim_now;
      base = (d == 0) ? 1 : d;
      n_pts = (d >= 8) ? $urandom_range(1, 3) : $urandom_range(1, 6);
      by_rule = ($urandom_range(9) < 7);
      for (int p = 0; p < n_pts; p++) begin
         n = base;
         case ($urandom_range(9))
            0: n = base + $urandom_range(1, 3);
            1: if (d > 1) begin
               n = $urandom_range(1, d - 1);
               if (!short_ok(n, d)) n = base;
            end
            default: ;
         endcase
         send_point(n, by_rule, p == n_pts - 1, $urandom_range(1));
      end
   endtask

   initial begin
      int run;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.coord = '0;
      req_ch.label = 1'b0;
      req_ch.last_coord = 1'b0;
      req_ch.last_point = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_DIMENSION;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      sender_pct = 0;
      receiver_pct = 0;
      beats_sent = 0;
      load_point = 0;
      dim_now = DIM_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes with reset settings, last point without last_coord.
      send_beat(32'sh7FFFFFFF, 1'b0, 1'b0, 1'b0);
      send_beat(32'sh80000000, 1'b0, 1'b1, 1'b0);
      send_beat(32'sh00000000, 1'b1, 1'b0, 1'b0);
      send_beat(32'shFFFFFFFF, 1'b1, 1'b0, 1'b1);
      for (int k = 0; k < 2; k++) slot_written[0][k] = 1'b1;
      for (int k = 0; k < 2; k++) slot_written[1][k] = 1'b1;
      req_ch.valid <= 1'b0;
      settle();

      // Full dimension, with coordinates beyond the store width dropped.
      write_reg(CSR_DIMENSION, 20'hF0010);
      write_reg(CSR_PASS_LIMIT, 20'hA0003);
      send_point(18, 1'b0, 1'b1, 1'b1);
      settle();

      // Bias alone, and no passes at all.
      write_reg(CSR_DIMENSION, 20'd0);
      write_reg(CSR_PASS_LIMIT, 20'd0);
      send_point(1, 1'b0, 1'b1, 1'b0);
      settle();

      // Short point reading older slots, then a dimension beyond the maximum.
      write_reg(CSR_DIMENSION, 20'd2);
      write_reg(CSR_PASS_LIMIT, 20'd5);
      write_reg(CSR_LEARNING_RATE, 20'd0);
      send_point(1, 1'b0, 1'b1, 1'b1);
      settle();
      write_reg(CSR_DIMENSION, 20'h0001F);
      write_reg(CSR_LEARNING_RATE, 20'hFFFFF);
      write_reg(CSR_PASS_LIMIT, 20'hFFFFF);
      send_beat(32'sh00010000, 1'b0, 1'b0, 1'b1);
      req_ch.valid <= 1'b0;
      settle();
      write_reg(CSR_DIMENSION, 20'd17);
      write_reg(CSR_PASS_LIMIT, 20'd4);
      write_reg(CSR_LEARNING_RATE, 20'd1);
      send_beat(32'sh80000000, 1'b1, 1'b1, 1'b1);
      req_ch.valid <= 1'b0;
      settle();

      run = 0;
      while (beats_sent < 440) begin
         case (run % 5)
            1: begin sender_pct = 57; receiver_pct = 0; end
            2: begin sender_pct = 0; receiver_pct = 57; end
            3: begin sender_pct = 28; receiver_pct = 28; end
            default: begin sender_pct = 0; receiver_pct = 0; end
         endcase
         if ($urandom_range(1)) begin
            case ($urandom_range(5))
               0: write_reg(CSR_DIMENSION,
                            {15'($urandom_range(32767)), 5'($urandom_range(17, 31))});
               1: write_reg(CSR_DIMENSION, 20'd16);
               default: write_reg(CSR_DIMENSION, 20'($urandom_range(0, 4)));
            endcase
            case ($urandom_range(3))
               0: write_reg(CSR_LEARNING_RATE, 20'($urandom));
               1: write_reg(CSR_LEARNING_RATE, 20'hFFFFF);
               default: write_reg(CSR_LEARNING_RATE, 20'($urandom_range(1 << 12, 1 << 17)));
            endcase
            write_reg(CSR_PASS_LIMIT, {4'($urandom), 16'($urandom_range(0, 12))});
         end
         random_run();
         settle();
         run++;
      end

      settle();
      repeat (40) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pt_pkg.sv
hw/rtl/pt_ifs.sv
hw/rtl/pt_store.sv
hw/rtl/pt_mac.sv
hw/rtl/perceptron_trainer.sv
tb/pt_checker.sv
tb/tb.sv
